// ===== sv/vrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrsp_pkg: shared constants for variable rate sample playback
// Field widths, request codes and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrsp_pkg;

  localparam int REQ_W      = 2;
  localparam int LOAD_ADR_W = 16;
  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 20;
  localparam int COUNT_W    = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  // Request codes carried by req_type.
  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PRODUCE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REWIND  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'd1;

  localparam logic [RATE_W-1:0] RATE_STEP_RST = 20'd65536;

endpackage

// ===== sv/vrsp_in_if.sv =====
// ----------------------------------------------------------------------------
// vrsp_in_if: request channel
// Valid/ready channel carrying load, produce and rewind requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vrsp_in_if import vrsp_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [LOAD_ADR_W-1:0]      load_address;
  logic signed [SAMPLE_W-1:0] load_value;

  modport source (output valid, output req_type, output load_address,
                  output load_value, input ready);
  modport sink (input valid, input req_type, input load_address,
                input load_value, output ready);
endinterface

// ===== sv/vrsp_out_if.sv =====
// ----------------------------------------------------------------------------
// vrsp_out_if: result channel
// Valid/ready channel carrying interpolated output samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vrsp_out_if import vrsp_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

// ===== sv/variable_rate_sample_playback_core.sv =====
// ----------------------------------------------------------------------------
// variable_rate_sample_playback_core: fractional rate sample playback
// Throughput: one request word per cycle unless the output stalls or the serial
//   modulo holds stage 1. A produce word's result passes stages 1, 2 and 3 and
//   the output register; when the playhead index lies at or beyond the sample
//   count, the serial modulo unit first reduces it. Loads and rewinds give no result.
// Reset: synchronous; playhead zero, rate 1.0, count 65536; store not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module variable_rate_sample_playback_core
  import vrsp_pkg::*;
#(
  parameter int ADDR_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vrsp_in_if.sink               in_ch,
  vrsp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH    = 1 << ADDR_BITS;
  localparam int PH_W     = ADDR_BITS + FRAC_BITS;
  localparam int CNT_W    = ADDR_BITS + 1;
  localparam int CMP_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int STEP_W   = FRAC_BITS + 4;
  localparam int STEP_UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int STEP_DN  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int WIDE_W   = RATE_W + STEP_UP;
  localparam int DIV_I_W  = $clog2(ADDR_BITS);
  localparam int PROD_W   = FRAC_BITS + SAMPLE_W + 2;
  localparam logic [CNT_W-1:0] CNT_RST = (ADDR_BITS >= 16) ?
                                         CNT_W'(32'd65536) : (CNT_W'(1) << ADDR_BITS);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(1) << ADDR_BITS;

  // Configuration and playhead.
  logic [RATE_W-1:0] rate_step_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PH_W-1:0]   ph_r, ph_nxt;

  logic signed [SAMPLE_W-1:0] sample_store [DEPTH];

  // Pipeline control.
  logic in_acc;
  logic o_free, s3_free, s2_free, s1_free, s1_adv, s1_go, s1_fast;
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;

  // Stage 1: index, fraction and serial modulo.
  logic [ADDR_BITS-1:0] s1_idx_r;
  logic [FRAC_BITS-1:0] s1_frac_r;
  logic                 div_act_r, div_done_r;
  logic [DIV_I_W-1:0]   div_i_r;
  logic [CNT_W-1:0]     rem_r, rem_sh, rem_step;
  logic [CNT_W-1:0]     s1_rem, s1_rem_inc;
  logic [ADDR_BITS-1:0] rd_addr_a, rd_addr_b;

  // Stage 2: neighbor samples.
  logic signed [SAMPLE_W-1:0] rd_a_r, rd_b_r;
  logic [FRAC_BITS-1:0]       s2_frac_r;
  logic signed [SAMPLE_W:0]   s2_diff;
  logic signed [PROD_W-1:0]   s2_prod;

  // Stage 3: product and base sample.
  logic signed [PROD_W-1:0]   s3_prod_r;
  logic signed [SAMPLE_W-1:0] s3_a_r;
  logic signed [SAMPLE_W+1:0] s3_sum;

  logic signed [SAMPLE_W-1:0] out_sample_r;

  // Playhead advance.
  logic [WIDE_W-1:0]  step_wide;
  logic [STEP_W-1:0]  step_s;
  logic [PH_W:0]      ph_sum, limit;
  logic [PH_W+1:0]    ph_wrap;
  logic [CMP_W-1:0]   cfg_cnt;

  // Handshake and stall chain.
  assign o_free  = !out_v_r || out_ch.ready;
  assign s3_free = !s3_v_r || o_free;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_adv  = s1_go && s2_free;
  assign s1_free = !s1_v_r || s1_adv;
  assign in_ch.ready = s1_free;
  assign in_acc  = in_ch.valid && s1_free;

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_sample = out_sample_r;

  // Rate step rescaled to the playhead's fraction width.
  assign step_wide = (WIDE_W'(rate_step_r) << STEP_UP) >> STEP_DN;
  assign step_s    = step_wide[STEP_W-1:0];
  assign ph_sum    = (PH_W+1)'(ph_r) + (PH_W+1)'(step_s);
  assign limit     = {cnt_r, {FRAC_BITS{1'b0}}};
  assign ph_wrap   = {1'b0, ph_sum} - {1'b0, limit};

  always_comb begin
    ph_nxt = ph_r;
    if (in_acc) begin
      case (in_ch.req_type)
        REQ_PRODUCE: begin
          ph_nxt = ph_wrap[PH_W+1] ? ph_sum[PH_W-1:0] : ph_wrap[PH_W-1:0];
        end
        REQ_REWIND: begin
          ph_nxt = '0;
        end
        default: begin
          ph_nxt = ph_r;
        end
      endcase
    end
  end

  // Count saturates to the store depth; zero acts as one.
  assign cfg_cnt = CMP_W'(cfg_wdata[COUNT_W-1:0]);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cfg_we && (cfg_idx == CFG_SAMPLE_COUNT)) begin
      if (cfg_cnt == '0) begin
        cnt_nxt = CNT_W'(1);
      end else if (cfg_cnt > DEPTH_CMP) begin
        cnt_nxt = DEPTH_CMP[CNT_W-1:0];
      end else begin
        cnt_nxt = cfg_cnt[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_step_r <= RATE_STEP_RST;
      cnt_r       <= CNT_RST;
      ph_r        <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      ph_r  <= ph_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_RATE_STEP: begin
            rate_step_r <= cfg_wdata[RATE_W-1:0];
          end
          default: begin
            rate_step_r <= rate_step_r;
          end
        endcase
      end
    end
  end

  // Loads write at acceptance, so a later produce, which reads from stage 1, sees the value.
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.req_type == REQ_LOAD)) begin
      sample_store[ADDR_BITS'(in_ch.load_address)] <= in_ch.load_value;
    end
  end

  // Stage 1 capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_acc && (in_ch.req_type == REQ_PRODUCE);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_idx_r  <= ph_r[PH_W-1:FRAC_BITS];
      s1_frac_r <= ph_r[FRAC_BITS-1:0];
    end
  end

  // An index at or beyond the count is reduced one bit per cycle, MSB first.
  assign s1_fast  = ({1'b0, s1_idx_r} < cnt_r);
  assign s1_go    = s1_v_r && (s1_fast || div_done_r);
  assign rem_sh   = {rem_r[CNT_W-2:0], s1_idx_r[div_i_r]};
  assign rem_step = (rem_sh >= cnt_r) ? (rem_sh - cnt_r) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_act_r  <= 1'b0;
      div_done_r <= 1'b0;
    end else if (s1_adv) begin
      div_act_r  <= 1'b0;
      div_done_r <= 1'b0;
    end else if (s1_v_r && !s1_fast && !div_act_r && !div_done_r) begin
      div_act_r <= 1'b1;
    end else if (div_act_r && (div_i_r == '0)) begin
      div_act_r  <= 1'b0;
      div_done_r <= 1'b1;
    end
  end

  // The remainder is held while a finished result waits for stage 2.
  always_ff @(posedge clk) begin
    if (!div_act_r && !div_done_r) begin
      rem_r   <= '0;
      div_i_r <= DIV_I_W'(ADDR_BITS - 1);
    end else if (div_act_r) begin
      rem_r   <= rem_step;
      div_i_r <= div_i_r - DIV_I_W'(1);
    end
  end

  assign s1_rem     = div_done_r ? rem_r : {1'b0, s1_idx_r};
  assign s1_rem_inc = s1_rem + CNT_W'(1);
  assign rd_addr_a  = s1_rem[ADDR_BITS-1:0];
  assign rd_addr_b  = (s1_rem_inc == cnt_r) ? '0 : s1_rem_inc[ADDR_BITS-1:0];

  // Stage 2: both neighbors read from the store.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rd_a_r    <= sample_store[rd_addr_a];
      rd_b_r    <= sample_store[rd_addr_b];
      s2_frac_r <= s1_frac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_adv;
    end
  end

  // a*(1-f) + b*f is evaluated as a + (b-a)*f.
  assign s2_diff = {rd_b_r[SAMPLE_W-1], rd_b_r} - {rd_a_r[SAMPLE_W-1], rd_a_r};
  assign s2_prod = PROD_W'(s2_diff) * PROD_W'($signed({1'b0, s2_frac_r}));

  always_ff @(posedge clk) begin
    if (s3_free && s2_v_r) begin
      s3_prod_r <= s2_prod;
      s3_a_r    <= rd_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_v_r;
    end
  end

  // Dropping the fraction bits of a signed product floors it.
  assign s3_sum = $signed(s3_prod_r[PROD_W-1:FRAC_BITS]) +
                  $signed({{2{s3_a_r[SAMPLE_W-1]}}, s3_a_r});

  always_ff @(posedge clk) begin
    if (o_free && s3_v_r) begin
      out_sample_r <= s3_sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (o_free) begin
      out_v_r <= s3_v_r;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for variable_rate_sample_playback_core
// Drives load, produce and rewind words through bursty traffic, predicts every
// interpolated sample from its own copy of the store and the playhead, and
// checks the result stream under a changing receiver stall pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import vrsp_pkg::*;

  localparam int ADDR_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int PH_W      = ADDR_BITS + FRAC_BITS;
  localparam int DEPTH     = 1 << ADDR_BITS;
  localparam int STEP_UP   = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
  localparam int STEP_DOWN = (FRAC_BITS >= 16) ? 0 : (16 - FRAC_BITS);
  // Worst case latency of a produce word, with the serial modulo, plus margin.
  localparam int SETTLE    = ADDR_BITS + 1 + 3 + 12;

  // The fourth request code has no meaning to the block and must be dropped.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]           kind;
    logic [LOAD_ADR_W-1:0]      addr;
    logic signed [SAMPLE_W-1:0] value;
  } play_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vrsp_in_if  in_ch ();
  vrsp_out_if out_ch ();

  variable_rate_sample_playback_core #(
    .ADDR_BITS(ADDR_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // Predictor state, updated as words are accepted.
  logic signed [SAMPLE_W-1:0] play_store [0:DEPTH-1];
  logic [PH_W-1:0]            play_head;
  logic [RATE_W-1:0]          play_rate;
  logic [COUNT_W-1:0]         play_count;
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  // Planning state, advanced as words are queued, so that no produce word
  // ever reads a store entry that was never loaded.
  bit                         loaded [0:DEPTH-1];
  logic [PH_W-1:0]            plan_head;
  logic [RATE_W-1:0]          plan_rate;
  logic [COUNT_W-1:0]         plan_count;
  play_word_t                 pending_words [$];

  int mismatches;

  function automatic int wrap_length(logic [COUNT_W-1:0] count);
    int c;
    c = int'(count);
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic void neighbor_slots(logic [PH_W-1:0] head, logic [COUNT_W-1:0] count,
                                         output int lo, output int hi);
    int idx;
    int cnt;
    idx = int'(head >> FRAC_BITS);
    cnt = wrap_length(count);
    lo  = idx % cnt;
    hi  = (idx + 1) % cnt;
  endfunction

  function automatic logic [PH_W-1:0] advance_head(logic [PH_W-1:0] head,
                                                   logic [RATE_W-1:0] rate,
                                                   logic [COUNT_W-1:0] count);
    logic [PH_W:0] sum;
    logic [PH_W:0] limit;
    sum   = {1'b0, head} + (((PH_W + 1)'(rate) << STEP_UP) >> STEP_DOWN);
    limit = (PH_W + 1)'(wrap_length(count)) << FRAC_BITS;
    if (sum >= limit) sum = sum - limit;
    return sum[PH_W-1:0];
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < 10) $display("%t tb_top: %s", $realtime, msg);
    mismatches++;
  endtask

  // Applies one accepted word to the predictor state.
  task automatic play_word(play_word_t w);
    int lo;
    int hi;
    longint frac;
    longint acc;
    logic signed [SAMPLE_W-1:0] mixed;
    case (w.kind)
      REQ_LOAD: begin
        play_store[w.addr] = w.value;
      end
      REQ_PRODUCE: begin
        neighbor_slots(play_head, play_count, lo, hi);
        frac  = longint'(play_head[FRAC_BITS-1:0]);
        acc   = longint'(play_store[lo]) * ((longint'(1) << FRAC_BITS) - frac)
              + longint'(play_store[hi]) * frac;
        // Arithmetic shift of the signed sum rounds toward minus infinity.
        mixed = SAMPLE_W'(acc >>> FRAC_BITS);
        expected_samples.push_back(mixed);
        play_head = advance_head(play_head, play_rate, play_count);
      end
      REQ_REWIND: begin
        play_head = '0;
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(logic [REQ_W-1:0] kind, logic [LOAD_ADR_W-1:0] addr,
                            logic signed [SAMPLE_W-1:0] value);
    play_word_t w;
    w.kind  = kind;
    w.addr  = addr;
    w.value = value;
    case (kind)
      REQ_LOAD:    loaded[addr] = 1'b1;
      REQ_PRODUCE: plan_head = advance_head(plan_head, plan_rate, plan_count);
      REQ_REWIND:  plan_head = '0;
      default: ;
    endcase
    pending_words.push_back(w);
  endtask

  // Loads any neighbor that is still empty, then queues the produce word.
  task automatic queue_produce();
    int lo;
    int hi;
    neighbor_slots(plan_head, plan_count, lo, hi);
    if (!loaded[lo]) queue_word(REQ_LOAD, LOAD_ADR_W'(lo), SAMPLE_W'($urandom));
    if (!loaded[hi]) queue_word(REQ_LOAD, LOAD_ADR_W'(hi), SAMPLE_W'($urandom));
    queue_word(REQ_PRODUCE, LOAD_ADR_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic queue_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_produce();
      end else if (pick < 70) begin
        queue_word(REQ_LOAD, LOAD_ADR_W'($urandom_range(0, wrap_length(plan_count) - 1)),
                   SAMPLE_W'($urandom));
      end else if (pick < 85) begin
        queue_word(REQ_LOAD, LOAD_ADR_W'($urandom), SAMPLE_W'($urandom));
      end else if (pick < 94) begin
        queue_word(REQ_REWIND, LOAD_ADR_W'($urandom), SAMPLE_W'($urandom));
      end else begin
        queue_word(REQ_UNUSED, LOAD_ADR_W'($urandom), SAMPLE_W'($urandom));
      end
    end
  endtask

  // Waits until every queued word is taken and every sample has come back.
  // The check runs on the falling edge, after the driver and monitor settle.
  task automatic drain();
    do
      @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_samples.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_RATE_STEP) begin
      play_rate = data[RATE_W-1:0];
      plan_rate = data[RATE_W-1:0];
    end else begin
      play_count = data[COUNT_W-1:0];
      plan_count = data[COUNT_W-1:0];
    end
  endtask

  // Request driver: bursts of random length separated by random gaps.
  int         burst_left;
  int         gap_left;
  play_word_t next_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        play_word({in_ch.req_type, in_ch.load_address, in_ch.load_value});
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.req_type     <= next_word.kind;
          in_ch.load_address <= next_word.addr;
          in_ch.load_value   <= next_word.value;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor; the stall pattern picks a new random mode whenever the 7-bit tick wraps.
  logic [1:0] stall_mode;
  logic [6:0] stall_tick;
  logic signed [SAMPLE_W-1:0] want_sample;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode   <= '0;
      stall_tick   <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch($sformatf("unexpected sample %0d", out_ch.out_sample));
        end else begin
          want_sample = expected_samples.pop_front();
          if (out_ch.out_sample !== want_sample)
            flag_mismatch($sformatf("out_sample expected %0d got %0d",
                                    want_sample, out_ch.out_sample));
        end
      end
      stall_tick <= stall_tick + 7'd1;
      if (stall_tick == '0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0:    out_ch.ready <= 1'b1;
        2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
        2'd2:    out_ch.ready <= (stall_tick[1:0] == 2'd0);
        default: out_ch.ready <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_RATE_STEP;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_LOAD;
    in_ch.load_address = '0;
    in_ch.load_value   = '0;
    out_ch.ready       = 1'b0;
    mismatches         = 0;
    play_head          = '0;
    play_rate          = RATE_STEP_RST;
    play_count         = COUNT_W'(DEPTH);
    plan_head          = '0;
    plan_rate          = RATE_STEP_RST;
    plan_count         = COUNT_W'(DEPTH);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: full-scale neighbors, an ignored code and a rewind.
    queue_word(REQ_LOAD, 16'h0000, 16'sh7FFF);
    queue_word(REQ_LOAD, 16'h0001, -16'sh8000);
    queue_word(REQ_LOAD, 16'hFFFF, -16'sh0001);
    queue_word(REQ_LOAD, 16'h0002, 16'sh0000);
    queue_produce();
    queue_produce();
    queue_produce();
    queue_word(REQ_UNUSED, 16'hFFFF, -16'sh0001);
    queue_word(REQ_REWIND, 16'hFFFF, 16'sh7FFF);
    queue_produce();
    drain();

    // Half rate lands halfway between the two extremes and must round down.
    write_reg(CFG_RATE_STEP, 20'h08000);
    queue_word(REQ_REWIND, '0, '0);
    repeat (4) queue_produce();
    drain();

    // Fastest rate over a loop of 16 samples wraps the playhead every word.
    write_reg(CFG_SAMPLE_COUNT, 20'd16);
    write_reg(CFG_RATE_STEP, 20'hFFFFF);
    repeat (5) queue_produce();
    drain();

    // Fast playback over the whole store carries the playhead far out.
    write_reg(CFG_SAMPLE_COUNT, 20'd65536);
    queue_random(150);
    drain();

    // Shrinking the loop below the playhead: reads wrap, advance subtracts once.
    write_reg(CFG_SAMPLE_COUNT, 20'd20);
    write_reg(CFG_RATE_STEP, 20'h01234);
    queue_random(120);
    drain();

    // A count of zero behaves as one, and a zero rate holds the playhead.
    write_reg(CFG_SAMPLE_COUNT, 20'd0);
    write_reg(CFG_RATE_STEP, 20'd0);
    queue_random(60);
    drain();

    // An oversized count saturates to the store depth; smallest nonzero rate.
    write_reg(CFG_SAMPLE_COUNT, 20'hFFFFF);
    write_reg(CFG_RATE_STEP, 20'd1);
    queue_random(100);
    drain();

    // Traffic stops halfway until every sample is back, then resumes.
    write_reg(CFG_SAMPLE_COUNT, 20'd37);
    write_reg(CFG_RATE_STEP, 20'h18000);
    queue_random(75);
    drain();
    queue_random(75);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'($urandom_range(16, DEPTH)));
      else
        write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'($urandom_range(16, 64)));
      write_reg(CFG_RATE_STEP, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
      queue_random(140);
      drain();
    end

    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
